@@ hdl/pra_pkg.sv @@
// ----------------------------------------------------------------------------
// pra_pkg: shared types and constants for the PageRank row accumulator
// Field widths, register codes and the control structs passed between the
// sequencer, the serial divider and the serial multiply-accumulate unit.
// ----------------------------------------------------------------------------
package pra_pkg;

    // Field widths
    localparam int ESC_W      = 16;   // escape probability, Q0.16
    localparam int PC_W       = 21;   // page count
    localparam int DEG_W      = 21;   // out-degree
    localparam int RANK_W     = 32;   // rank, Q0.32
    localparam int SUM_W      = 48;   // row sum, Q16.32
    localparam int WGT_W      = 33;   // weight, Q1.32 (at most 1.0)
    localparam int DIVD_W     = 33;   // dividend of the weight division
    localparam int SHARE_W    = 32;   // escape share e/N, Q0.32
    localparam int CFG_DATA_W = 21;
    localparam int CFG_IDX_W  = 1;

    // Serial step counters
    localparam int DIV_CNT_W = $clog2(DIVD_W);
    localparam int MUL_CNT_W = $clog2(WGT_W);

    // Page count limit and register reset values
    localparam int MAX_PAGES = 1048576;
    localparam logic [PC_W-1:0]  PAGES_CAP   = PC_W'(MAX_PAGES);
    localparam logic [ESC_W-1:0] ESC_RESET   = ESC_W'(9830);
    localparam logic [PC_W-1:0]  PAGES_RESET = PC_W'(1);

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ESCAPE = 1'b0,
        CFG_PAGES  = 1'b1
    } t_cfg_idx;

    // Divider request and status
    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DEG_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // Multiply-accumulate request and status
    typedef struct packed {
        logic              start;
        logic [WGT_W-1:0]  weight;
        logic [RANK_W-1:0] rank;
        logic              last;
    } t_mac_req;

    typedef struct packed {
        logic ready;
    } t_mac_stat;

endpackage

@@ hdl/pra_in_if.sv @@
// ----------------------------------------------------------------------------
// pra_in_if: page beat channel
// Valid/ready channel carrying one page of the row per beat.
// ----------------------------------------------------------------------------
interface pra_in_if;
    import pra_pkg::*;

    logic              valid;
    logic              ready;
    logic              linked;
    logic [DEG_W-1:0]  out_degree;
    logic [RANK_W-1:0] rank_value;
    logic              last_page;

    modport source (
        output valid, linked, out_degree, rank_value, last_page,
        input  ready
    );

    modport sink (
        input  valid, linked, out_degree, rank_value, last_page,
        output ready
    );

endinterface

@@ hdl/pra_out_if.sv @@
// ----------------------------------------------------------------------------
// pra_out_if: row result channel
// Valid/ready channel carrying one row sum per beat.
// ----------------------------------------------------------------------------
interface pra_out_if;
    import pra_pkg::*;

    logic             valid;
    logic             ready;
    logic [SUM_W-1:0] row_sum;
    logic             saturated;

    modport source (
        output valid, row_sum, saturated,
        input  ready
    );

    modport sink (
        input  valid, row_sum, saturated,
        output ready
    );

endinterface

@@ hdl/pra_div.sv @@
// ----------------------------------------------------------------------------
// pra_div: radix-2 restoring divider
// Produces one quotient bit per cycle; the dividend register shifts left and
// collects the quotient bits, so it holds the quotient when done pulses.
// ----------------------------------------------------------------------------
module pra_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  pra_pkg::t_div_req              i_req,
    output pra_pkg::t_div_stat             o_stat,
    output logic [pra_pkg::DIVD_W-1:0]     o_quotient
);
    import pra_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DEG_W-1:0]     r_rem;
    logic [DIVD_W-1:0]    r_dvd;
    logic [DEG_W-1:0]     r_dsr;

    logic [DEG_W:0]       trial;
    logic [DEG_W:0]       diff;
    logic                 q_bit;

    // Trial subtract of the divisor from the shifted remainder
    always_comb begin
        trial = {r_rem, r_dvd[DIVD_W-1]};
        diff  = trial - {1'b0, r_dsr};
        q_bit = (trial >= {1'b0, r_dsr});
    end

    // Load on start, then step once per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIVD_W - 1);
                r_rem  <= '0;
                r_dvd  <= i_req.dividend;
                r_dsr  <= i_req.divisor;
            end else if (r_busy) begin
                r_rem <= q_bit ? diff[DEG_W-1:0] : trial[DEG_W-1:0];
                r_dvd <= {r_dvd[DIVD_W-2:0], q_bit};
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_dvd;

`ifndef SYNTH
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a running division");
`endif

endmodule

@@ hdl/pra_mac.sv @@
// ----------------------------------------------------------------------------
// pra_mac: serial multiply and saturating row accumulate
// Multiplies rank by weight one weight bit per cycle (shift-add), adds the
// upper product bits into the Q16.32 row sum and emits it on the last page.
// ----------------------------------------------------------------------------
module pra_mac (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pra_pkg::t_mac_req             i_req,
    output pra_pkg::t_mac_stat            o_stat,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [pra_pkg::SUM_W-1:0]     o_row_sum,
    output logic                          o_saturated
);
    import pra_pkg::*;

    typedef enum logic [1:0] {
        M_IDLE,
        M_MUL,
        M_ACC
    } t_mstate;

    t_mstate              r_state;
    logic [MUL_CNT_W-1:0] r_cnt;
    logic [RANK_W-1:0]    r_hi;
    logic [WGT_W-1:0]     r_lo;
    logic [RANK_W-1:0]    r_rank;
    logic                 r_last;
    logic [SUM_W-1:0]     r_acc;
    logic                 r_clip;
    logic                 r_out_valid;
    logic [SUM_W-1:0]     r_out_sum;
    logic                 r_out_sat;

    logic [RANK_W:0]      step_sum;
    logic [WGT_W-1:0]     term;
    logic [SUM_W:0]       acc_sum;
    logic [SUM_W-1:0]     acc_next;
    logic                 clip_next;

    // Shift-add step and saturating accumulate
    always_comb begin
        step_sum  = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_rank} : '0);
        term      = {r_hi, r_lo[WGT_W-1]};
        acc_sum   = {1'b0, r_acc} + (SUM_W+1)'(term);
        acc_next  = acc_sum[SUM_W] ? '1 : acc_sum[SUM_W-1:0];
        clip_next = r_clip | acc_sum[SUM_W];
    end

    // Sequencer, accumulator and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= M_IDLE;
            r_cnt       <= '0;
            r_acc       <= '0;
            r_clip      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready && !(r_state == M_ACC && r_last)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                M_IDLE: begin
                    if (i_req.start) begin
                        r_hi    <= '0;
                        r_lo    <= i_req.weight;
                        r_rank  <= i_req.rank;
                        r_last  <= i_req.last;
                        r_cnt   <= MUL_CNT_W'(WGT_W - 1);
                        r_state <= M_MUL;
                    end
                end
                M_MUL: begin
                    r_hi <= step_sum[RANK_W:1];
                    r_lo <= {step_sum[0], r_lo[WGT_W-1:1]};
                    if (r_cnt == '0) begin
                        r_state <= M_ACC;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                M_ACC: begin
                    if (!r_last) begin
                        r_acc   <= acc_next;
                        r_clip  <= clip_next;
                        r_state <= M_IDLE;
                    end else if (!r_out_valid || i_ready) begin
                        // Emit the row and clear for the next one
                        r_out_sum   <= acc_next;
                        r_out_sat   <= clip_next;
                        r_out_valid <= 1'b1;
                        r_acc       <= '0;
                        r_clip      <= 1'b0;
                        r_state     <= M_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_stat.ready = (r_state == M_IDLE);
    assign o_valid      = r_out_valid;
    assign o_row_sum    = r_out_sum;
    assign o_saturated  = r_out_sat;

`ifndef SYNTH
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clip |-> (&r_acc))
        else $error("clip flag set while row sum is below its maximum");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == M_ACC && r_last && r_out_valid && !i_ready) |=> (r_state == M_ACC))
        else $error("row result left the accumulator while output is full");
`endif

endmodule

@@ hdl/pagerank_row_accumulate_core.sv @@
// ----------------------------------------------------------------------------
// pagerank_row_accumulate_core: one row of the PageRank matrix times ranks
// Takes one page per beat (linked flag, out-degree, Q0.32 rank, last mark),
// weights the rank by (1-e)/deg + e/N, 1/N for dangling pages, or e/N, and
// adds it into a saturating Q16.32 row sum that is emitted on the last page.
// A page goes through a 33-step radix-2 divider that forms the weight and
// a 33-step bit-serial multiplier that applies it, the two working on
// consecutive pages side by side. The escape share e/N is cached; the first
// page after reset or after a register write that needs it first passes
// through the divider to rebuild it. Pages that need no division
// (unlinked, nonzero out-degree, share cached) are limited by the multiplier.
// ----------------------------------------------------------------------------
module pagerank_row_accumulate_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pra_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [pra_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    pra_in_if.sink                            i_in,
    pra_out_if.source                         o_out
);
    import pra_pkg::*;

    typedef enum logic [1:0] {
        D_IDLE,
        D_SHARE,
        D_WEIGHT,
        D_HAND
    } t_dstate;

    t_dstate            r_dstate;
    logic [ESC_W-1:0]   r_escape;
    logic [PC_W-1:0]    r_pages;
    logic [SHARE_W-1:0] r_share;
    logic               r_share_valid;
    logic               r_linked;
    logic [DEG_W-1:0]   r_deg;
    logic [RANK_W-1:0]  r_rank;
    logic               r_last;
    logic               r_add_share;
    logic [WGT_W-1:0]   r_weight;

    logic [PC_W-1:0]    pages_eff;
    logic [DIVD_W-1:0]  share_dvd;
    logic [DIVD_W-1:0]  link_dvd;
    logic [DIVD_W-1:0]  dangle_dvd;
    logic               in_acc;
    t_div_req           div_req;
    t_div_stat          div_stat;
    logic [DIVD_W-1:0]  div_quot;
    t_mac_req           mac_req;
    t_mac_stat          mac_stat;

    // Clamp page count into 1..MAX_PAGES and build the dividends
    always_comb begin
        if (r_pages == '0) begin
            pages_eff = PC_W'(1);
        end else if (r_pages > PAGES_CAP) begin
            pages_eff = PAGES_CAP;
        end else begin
            pages_eff = r_pages;
        end
        share_dvd  = {1'b0, r_escape, {ESC_W{1'b0}}};
        link_dvd   = {((ESC_W+1)'(1) << ESC_W) - {1'b0, r_escape}, {ESC_W{1'b0}}};
        dangle_dvd = {1'b1, {(DIVD_W-1){1'b0}}};
    end

    assign i_in.ready = (r_dstate == D_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;

    // Divider launches: on an accepted page, or after the share is rebuilt for a linked page
    always_comb begin
        div_req = '0;
        if (in_acc) begin
            if (i_in.out_degree == '0) begin
                div_req.start    = 1'b1;
                div_req.dividend = dangle_dvd;
                div_req.divisor  = DEG_W'(pages_eff);
            end else if (!r_share_valid) begin
                div_req.start    = 1'b1;
                div_req.dividend = share_dvd;
                div_req.divisor  = DEG_W'(pages_eff);
            end else if (i_in.linked) begin
                div_req.start    = 1'b1;
                div_req.dividend = link_dvd;
                div_req.divisor  = i_in.out_degree;
            end
        end else if (r_dstate == D_SHARE && div_stat.done && r_linked) begin
            div_req.start    = 1'b1;
            div_req.dividend = link_dvd;
            div_req.divisor  = r_deg;
        end
    end

    // Hand the finished weight to the multiplier
    always_comb begin
        mac_req.start  = (r_dstate == D_HAND) && mac_stat.ready;
        mac_req.weight = r_weight;
        mac_req.rank   = r_rank;
        mac_req.last   = r_last;
    end

    // Page sequencer and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dstate      <= D_IDLE;
            r_escape      <= ESC_RESET;
            r_pages       <= PAGES_RESET;
            r_share_valid <= 1'b0;
        end else begin
            unique case (r_dstate)
                D_IDLE: begin
                    if (in_acc) begin
                        r_linked <= i_in.linked;
                        r_deg    <= i_in.out_degree;
                        r_rank   <= i_in.rank_value;
                        r_last   <= i_in.last_page;
                        if (i_in.out_degree == '0) begin
                            r_add_share <= 1'b0;
                            r_dstate    <= D_WEIGHT;
                        end else if (!r_share_valid) begin
                            r_dstate <= D_SHARE;
                        end else if (i_in.linked) begin
                            r_add_share <= 1'b1;
                            r_dstate    <= D_WEIGHT;
                        end else begin
                            r_weight <= {1'b0, r_share};
                            r_dstate <= D_HAND;
                        end
                    end
                end
                D_SHARE: begin
                    if (div_stat.done) begin
                        r_share       <= div_quot[SHARE_W-1:0];
                        r_share_valid <= 1'b1;
                        if (r_linked) begin
                            r_add_share <= 1'b1;
                            r_dstate    <= D_WEIGHT;
                        end else begin
                            r_weight <= {1'b0, div_quot[SHARE_W-1:0]};
                            r_dstate <= D_HAND;
                        end
                    end
                end
                D_WEIGHT: begin
                    if (div_stat.done) begin
                        r_weight <= div_quot + (r_add_share ? {1'b0, r_share} : '0);
                        r_dstate <= D_HAND;
                    end
                end
                D_HAND: begin
                    if (mac_stat.ready) begin
                        r_dstate <= D_IDLE;
                    end
                end
            endcase

            // Register writes drop the cached escape share
            if (i_cfg_we) begin
                r_share_valid <= 1'b0;
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_ESCAPE: r_escape <= i_cfg_data[ESC_W-1:0];
                    CFG_PAGES:  r_pages  <= i_cfg_data[PC_W-1:0];
                endcase
            end
        end
    end

    pra_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .o_stat     (div_stat),
        .o_quotient (div_quot)
    );

    pra_mac u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (mac_req),
        .o_stat      (mac_stat),
        .o_valid     (o_out.valid),
        .i_ready     (o_out.ready),
        .o_row_sum   (o_out.row_sum),
        .o_saturated (o_out.saturated)
    );

`ifndef SYNTH
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_share_valid) |-> ($past(i_cfg_we) || $past(!i_rst_n)))
        else $error("escape share dropped without a register write");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.out_degree == '0) |=> (r_dstate == D_WEIGHT))
        else $error("dangling page did not go straight to its weight division");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_dstate == D_SHARE || r_dstate == D_WEIGHT))
        else $error("division finished with no page waiting for it");
`endif

endmodule

@@ dv/tb_pagerank_row_accumulate_core.sv @@
// ----------------------------------------------------------------------------
// tb_pagerank_row_accumulate_core: self-checking bench for the row accumulator
// Drives page beats through a directed table and then random rows under
// changing escape and page-count settings. Every beat is folded into a local
// fixed-point copy of the row sum. Returned row sums are compared field by
// field in order. Idling on both channels varies by phase, and one long
// hold-off on the result side backs the block up.
// ----------------------------------------------------------------------------
module tb_pagerank_row_accumulate_core;
    import pra_pkg::*;

    localparam int SETTLE_CYCLES   = 100;      // covers divider plus multiplier
    localparam int DRAIN_CYCLES    = 200;
    localparam int RUN_LIMIT       = 20000000;
    localparam int PHASE_PAGES     = 533;
    localparam int HOLD_OFF_CYCLES = 3000;
    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    typedef enum logic {ROW_PAGE, ROW_WRITE} t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        t_cfg_idx              cfg_idx;
        logic [CFG_DATA_W-1:0] cfg_data;
        logic                  linked;
        logic [DEG_W-1:0]      out_degree;
        logic [RANK_W-1:0]     rank_value;
        logic                  last_page;
        logic                  typed;
        logic [SUM_W-1:0]      typed_sum;
        logic                  typed_sat;
    } t_stim_row;

    typedef struct packed {
        logic [SUM_W-1:0] row_sum;
        logic             saturated;
    } t_row_result;

    // Directed table; typed sums hold for the settings in force at that row
    localparam int DIRECTED_ROWS = 22;
    localparam t_stim_row DIRECTED [DIRECTED_ROWS] = '{
        // reset settings: e = 9830, N = 1
        '{ROW_PAGE,  CFG_ESCAPE, 21'h0,      1'b0, 21'h0,      32'h0,        1'b1, 1'b1,
          48'h0,            1'b0},
        '{ROW_PAGE,  CFG_ESCAPE, 21'h0,      1'b0, 21'h0,      32'hFFFF_FFFF, 1'b1, 1'b1,
          48'hFFFF_FFFF,    1'b0},
        '{ROW_PAGE,  CFG_ESCAPE, 21'h0,      1'b1, 21'h1,      32'hFFFF_FFFF, 1'b1, 1'b1,
          48'hFFFF_FFFF,    1'b0},
        '{ROW_PAGE,  CFG_ESCAPE, 21'h0,      1'b0, 21'h1F_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1,
          48'h2665_FFFF,    1'b0},
        '{ROW_PAGE,  CFG_ESCAPE, 21'h0,      1'b1, 21'h1F_FFFF, 32'hAAAA_AAAA, 1'b0, 1'b0,
          48'h0,            1'b0},
        '{ROW_PAGE,  CFG_ESCAPE, 21'h0,      1'b1, 21'h2,      32'h5555_5555, 1'b0, 1'b0,
          48'h0,            1'b0},
        '{ROW_PAGE,  CFG_ESCAPE, 21'h0,      1'b0, 21'h10_0000, 32'h1234_5678, 1'b1, 1'b0,
          48'h0,            1'b0},
        // no escape: unlinked pages weigh nothing, a linked single link weighs 1.0
        '{ROW_WRITE, CFG_ESCAPE, 21'h0,      1'b0, 21'h0,      32'h0,        1'b0, 1'b0,
          48'h0,            1'b0},
        '{ROW_PAGE,  CFG_ESCAPE, 21'h0,      1'b0, 21'h7,      32'hFFFF_FFFF, 1'b1, 1'b1,
          48'h0,            1'b0},
        '{ROW_PAGE,  CFG_ESCAPE, 21'h0,      1'b1, 21'h1,      32'hFFFF_FFFF, 1'b1, 1'b1,
          48'hFFFF_FFFF,    1'b0},
        // upper data bits drop, escape becomes 0xFFFF
        '{ROW_WRITE, CFG_ESCAPE, 21'h1F_FFFF, 1'b0, 21'h0,      32'h0,        1'b0, 1'b0,
          48'h0,            1'b0},
        '{ROW_PAGE,  CFG_ESCAPE, 21'h0,      1'b0, 21'h3,      32'hFFFF_FFFF, 1'b1, 1'b1,
          48'hFFFE_FFFF,    1'b0},
        // page count zero acts as one
        '{ROW_WRITE, CFG_PAGES,  21'h0,      1'b0, 21'h0,      32'h0,        1'b0, 1'b0,
          48'h0,            1'b0},
        '{ROW_PAGE,  CFG_ESCAPE, 21'h0,      1'b0, 21'h0,      32'hFFFF_FFFF, 1'b1, 1'b1,
          48'hFFFF_FFFF,    1'b0},
        // page count above the cap clamps; a linked dangling page still gets 1/N
        '{ROW_WRITE, CFG_PAGES,  21'h1F_FFFF, 1'b0, 21'h0,      32'h0,        1'b0, 1'b0,
          48'h0,            1'b0},
        '{ROW_PAGE,  CFG_ESCAPE, 21'h0,      1'b1, 21'h0,      32'hFFFF_FFFF, 1'b1, 1'b1,
          48'hFFF,          1'b0},
        '{ROW_WRITE, CFG_PAGES,  21'h10_0000, 1'b0, 21'h0,      32'h0,        1'b0, 1'b0,
          48'h0,            1'b0},
        '{ROW_PAGE,  CFG_ESCAPE, 21'h0,      1'b0, 21'h0,      32'hFFFF_FFFF, 1'b0, 1'b0,
          48'h0,            1'b0},
        '{ROW_PAGE,  CFG_ESCAPE, 21'h0,      1'b0, 21'h0,      32'hFFFF_FFFF, 1'b1, 1'b1,
          48'h1FFE,         1'b0},
        // out-degree above the page count is taken as given
        '{ROW_WRITE, CFG_PAGES,  21'h3,      1'b0, 21'h0,      32'h0,        1'b0, 1'b0,
          48'h0,            1'b0},
        '{ROW_PAGE,  CFG_ESCAPE, 21'h0,      1'b1, 21'h5,      32'h8000_0000, 1'b0, 1'b0,
          48'h0,            1'b0},
        '{ROW_PAGE,  CFG_ESCAPE, 21'h0,      1'b0, 21'h9,      32'hFFFF_FFFF, 1'b1, 1'b0,
          48'h0,            1'b0}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    pra_in_if  page_ch ();
    pra_out_if sum_ch ();

    pagerank_row_accumulate_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (page_ch),
        .o_out      (sum_ch)
    );

    // Local copy of the registers and the running row sum
    logic [ESC_W-1:0]  escape_reg = ESC_RESET;
    logic [PC_W-1:0]   pages_reg  = PAGES_RESET;
    logic [SUM_W-1:0]  row_total  = '0;
    logic              row_clipped = 1'b0;
    t_row_result       expected_sums [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_off_request = 1'b0;
    int mismatch_count = 0;
    int cycle_count = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("[pagerank_row_accumulate_core] ERROR");
            $finish;
        end
    end

    // Weighted rank of one page: rank times its Q1.32 weight, truncated
    function automatic logic [63:0] weighted_rank(logic linked, logic [DEG_W-1:0] deg,
                                                  logic [RANK_W-1:0] rank);
        logic [63:0] pages;
        logic [63:0] share;
        logic [63:0] weight;
        logic [63:0] product;
        if (pages_reg == '0)
            pages = 64'd1;
        else if (pages_reg > PAGES_CAP)
            pages = 64'(MAX_PAGES);
        else
            pages = 64'(pages_reg);
        share = {32'd0, escape_reg, 16'd0} / pages;
        if (deg == '0)
            weight = 64'h1_0000_0000 / pages;
        else if (linked)
            weight = ((64'd65536 - 64'(escape_reg)) << 16) / 64'(deg) + share;
        else
            weight = share;
        product = 64'(rank) * weight;
        return product >> 32;
    endfunction

    // Add one accepted page to the row sum; close the row on its last page
    function automatic void fold_page(t_stim_row row);
        logic [63:0] term;
        t_row_result result;
        term = weighted_rank(row.linked, row.out_degree, row.rank_value);
        if (term > 64'(SUM_MAX - row_total)) begin
            row_total   = SUM_MAX;
            row_clipped = 1'b1;
        end else begin
            row_total = row_total + term[SUM_W-1:0];
        end
        if (row.last_page) begin
            result.row_sum   = row.typed ? row.typed_sum : row_total;
            result.saturated = row.typed ? row.typed_sat : row_clipped;
            expected_sums.push_back(result);
            row_total   = '0;
            row_clipped = 1'b0;
        end
    endfunction

    // Offer one page beat, with random idle cycles ahead of it
    task automatic drive_page(t_stim_row row);
        while ($urandom_range(99) < send_idle_pct) begin
            page_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        page_ch.valid      <= 1'b1;
        page_ch.linked     <= row.linked;
        page_ch.out_degree <= row.out_degree;
        page_ch.rank_value <= row.rank_value;
        page_ch.last_page  <= row.last_page;
        do @(posedge i_clk); while (page_ch.ready !== 1'b1);
        fold_page(row);
    endtask

    // Write a register once the block has drained
    task automatic write_register(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        page_ch.valid <= 1'b0;
        while (expected_sums.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_ESCAPE)
            escape_reg = data[ESC_W-1:0];
        else
            pages_reg = data;
    endtask

    task automatic random_setting();
        logic [CFG_DATA_W-1:0] data;
        if ($urandom_range(1) == 0) begin
            case ($urandom_range(3))
                0:       data = '0;
                1:       data = CFG_DATA_W'(16'hFFFF);
                default: data = CFG_DATA_W'($urandom);
            endcase
            write_register(CFG_ESCAPE, data);
        end else begin
            case ($urandom_range(7))
                0:       data = '0;
                1:       data = CFG_DATA_W'(1);
                2:       data = PAGES_CAP;
                3:       data = '1;
                4, 5:    data = CFG_DATA_W'($urandom_range(2, 64));
                default: data = CFG_DATA_W'($urandom);
            endcase
            write_register(CFG_PAGES, data);
        end
    endtask

    function automatic t_stim_row random_page(logic last);
        t_stim_row row;
        row           = '0;
        row.kind      = ROW_PAGE;
        row.linked    = 1'($urandom);
        row.last_page = last;
        case ($urandom_range(9))
            0:          row.out_degree = '0;
            1:          row.out_degree = '1;
            2, 3, 4, 5: row.out_degree = DEG_W'($urandom_range(1, 16));
            default:    row.out_degree = DEG_W'($urandom);
        endcase
        case ($urandom_range(7))
            0:       row.rank_value = '0;
            1:       row.rank_value = '1;
            default: row.rank_value = $urandom;
        endcase
        return row;
    endfunction

    // Random rows, mostly short, with occasional setting changes between rows
    task automatic run_random_rows(int pages_wanted);
        int sent;
        int len;
        int k;
        sent = 0;
        while (sent < pages_wanted) begin
            if ($urandom_range(7) == 0)
                random_setting();
            case ($urandom_range(19))
                0:              len = $urandom_range(25, 60);
                1, 2, 3, 4, 5:  len = $urandom_range(7, 24);
                default:        len = $urandom_range(1, 6);
            endcase
            for (k = 0; k < len; k++)
                drive_page(random_page(k == len - 1));
            sent += len;
        end
    endtask

    // Result side: check each beat, then pick the next ready level
    initial begin
        t_row_result want;
        int hold_left;
        hold_left = 0;
        sum_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && sum_ch.valid && sum_ch.ready) begin
                if (expected_sums.size() == 0) begin
                    $error("unexpected row beat: row_sum %0h saturated %0b",
                           sum_ch.row_sum, sum_ch.saturated);
                    mismatch_count++;
                end else begin
                    want = expected_sums.pop_front();
                    if (sum_ch.row_sum !== want.row_sum) begin
                        $error("row_sum mismatch: expected %0h, actual %0h",
                               want.row_sum, sum_ch.row_sum);
                        mismatch_count++;
                    end
                    if (sum_ch.saturated !== want.saturated) begin
                        $error("saturated mismatch: expected %0b, actual %0b",
                               want.saturated, sum_ch.saturated);
                        mismatch_count++;
                    end
                end
            end
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (!i_rst_n || hold_left != 0)
                sum_ch.ready <= 1'b0;
            else
                sum_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            if (hold_left != 0)
                hold_left--;
        end
    end

    // Stimulus: reset, directed table, random phases, drain
    initial begin
        int r;
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_idx          <= CFG_ESCAPE;
        i_cfg_data         <= '0;
        page_ch.valid      <= 1'b0;
        page_ch.linked     <= 1'b0;
        page_ch.out_degree <= '0;
        page_ch.rank_value <= '0;
        page_ch.last_page  <= 1'b0;
        send_idle_pct = 22;
        recv_idle_pct = 87;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (r = 0; r < DIRECTED_ROWS; r++) begin
            if (DIRECTED[r].kind == ROW_WRITE)
                write_register(DIRECTED[r].cfg_idx, DIRECTED[r].cfg_data);
            else
                drive_page(DIRECTED[r]);
        end

        run_random_rows(PHASE_PAGES);

        // swap the idling of the two sides
        send_idle_pct = 87;
        recv_idle_pct = 22;
        run_random_rows(PHASE_PAGES);

        // no idling; hold the result side off so the block backs up
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_request = 1'b1;
        run_random_rows(PHASE_PAGES);

        for (r = 0; r < 3; r++)
            drive_page(random_page(r == 2));
        page_ch.valid <= 1'b0;

        while (expected_sums.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("[pagerank_row_accumulate_core] OK");
        else
            $display("[pagerank_row_accumulate_core] ERROR");
        $finish;
    end

endmodule
